/* sv/bir_pkg.sv */
// ----------------------------------------------------------------------------
// bir_pkg - shared constants for the box overlap ratio block
// Default coordinate and fraction widths used by every module.
// ----------------------------------------------------------------------------
`default_nettype none

package bir_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

endpackage

`default_nettype wire

/* sv/bir_geom.sv */
// ----------------------------------------------------------------------------
// bir_geom - box geometry front end
// Four register stages: edges, overlap extents and box areas, intersection
// and area sum, union and empty flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_geom
  import bir_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [COORD_BITS-1:0]     first_x,
  input  wire logic [COORD_BITS-1:0]     first_y,
  input  wire logic [COORD_BITS-1:0]     first_width,
  input  wire logic [COORD_BITS-1:0]     first_height,
  input  wire logic [COORD_BITS-1:0]     second_x,
  input  wire logic [COORD_BITS-1:0]     second_y,
  input  wire logic [COORD_BITS-1:0]     second_width,
  input  wire logic [COORD_BITS-1:0]     second_height,
  output logic                           out_valid,
  output logic [2*COORD_BITS-1:0]        inter,
  output logic [2*COORD_BITS:0]          uni,
  output logic                           empty
);

  localparam int C = COORD_BITS;
  localparam int E = COORD_BITS + 1;
  localparam int A = 2 * COORD_BITS;

  // stage 1: right and bottom edges, larger left and top edge
  logic         v1;
  logic [E-1:0] xr1, xr2, yb1, yb2;
  logic [C-1:0] xl, yt;
  logic [C-1:0] w1, h1, w2, h2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr1 <= {1'b0, first_x} + {1'b0, first_width};
      xr2 <= {1'b0, second_x} + {1'b0, second_width};
      yb1 <= {1'b0, first_y} + {1'b0, first_height};
      yb2 <= {1'b0, second_y} + {1'b0, second_height};
      xl  <= (first_x > second_x) ? first_x : second_x;
      yt  <= (first_y > second_y) ? first_y : second_y;
      w1  <= first_width;
      h1  <= first_height;
      w2  <= second_width;
      h2  <= second_height;
    end
  end

  // stage 2: clamped overlap extents, box areas
  logic         v2;
  logic [C-1:0] iw, ih;
  logic [A-1:0] area1, area2;
  logic [E-1:0] xhi, ylo;
  logic [C-1:0] iw_next, ih_next;

  always_comb begin
    xhi = (xr1 < xr2) ? xr1 : xr2;
    ylo = (yb1 < yb2) ? yb1 : yb2;
    // extent never exceeds the smaller size, so it fits in C bits
    iw_next = (xhi > {1'b0, xl}) ? C'(xhi - {1'b0, xl}) : '0;
    ih_next = (ylo > {1'b0, yt}) ? C'(ylo - {1'b0, yt}) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iw    <= iw_next;
      ih    <= ih_next;
      area1 <= A'(w1) * A'(h1);
      area2 <= A'(w2) * A'(h2);
    end
  end

  // stage 3: intersection area and sum of areas
  logic         v3;
  logic [A-1:0] inter3;
  logic [A:0]   asum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inter3 <= A'(iw) * A'(ih);
      asum   <= {1'b0, area1} + {1'b0, area2};
    end
  end

  // stage 4: union, zero union when the area sum equals the intersection
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inter <= inter3;
      uni   <= asum - {1'b0, inter3};
      empty <= (asum == {1'b0, inter3});
    end
  end

endmodule

`default_nettype wire

/* sv/bir_div_step.sv */
// ----------------------------------------------------------------------------
// bir_div_step - one restoring division stage
// Shifts in one dividend bit, compares with the divisor and produces one
// quotient bit; all operands travel on to the next stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_div_step
  import bir_pkg::*;
#(
  parameter int DW = 2 * COORD_BITS_DEF + 1,
  parameter int QW = FRAC_BITS_DEF + 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] rem_in,
  input  wire logic [DW-1:0] den_in,
  input  wire logic [QW-1:0] nb_in,
  input  wire logic [QW-1:0] q_in,
  input  wire logic          empty_in,
  output logic               out_valid,
  output logic [DW-1:0]      rem_out,
  output logic [DW-1:0]      den_out,
  output logic [QW-1:0]      nb_out,
  output logic [QW-1:0]      q_out,
  output logic               empty_out
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_next;

  always_comb begin
    trial = {rem_in, nb_in[QW-1]};
    diff  = trial - {1'b0, den_in};
    ge    = (trial >= {1'b0, den_in});
    // remainder stays below the divisor, so DW bits hold it
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out   <= rem_next;
      den_out   <= den_in;
      nb_out    <= {nb_in[QW-2:0], 1'b0};
      q_out     <= {q_in[QW-2:0], ge};
      empty_out <= empty_in;
    end
  end

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && !empty_out |-> rem_out < den_out)
    else $error("division remainder not below divisor");
`endif

endmodule

`default_nettype wire

/* sv/bir_divider.sv */
// ----------------------------------------------------------------------------
// bir_divider - pipelined fixed-point divider
// Computes floor(inter * 2^FRAC_BITS / uni), one quotient bit per stage,
// and forces zero when the union is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_divider
  import bir_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [2*COORD_BITS-1:0] inter,
  input  wire logic [2*COORD_BITS:0]   uni,
  input  wire logic                    empty,
  output logic                         out_valid,
  output logic [FRAC_BITS:0]           ratio,
  output logic                         out_empty
);

  localparam int QW = FRAC_BITS + 1;
  localparam int DW = 2 * COORD_BITS + 1;

  logic          vld  [0:QW];
  logic [DW-1:0] rem  [0:QW];
  logic [DW-1:0] den  [0:QW];
  logic [QW-1:0] nb   [0:QW];
  logic [QW-1:0] quo  [0:QW];
  logic          emp  [0:QW];

  // quotient is at most 2^FRAC_BITS, so the dividend shifted down by QW
  // (inter >> 1) already sits below the divisor; only inter[0] remains to
  // be shifted in, followed by zeros
  assign vld[0] = in_valid;
  assign rem[0] = DW'(inter[2*COORD_BITS-1:1]);
  assign den[0] = uni;
  assign nb[0]  = {inter[0], {FRAC_BITS{1'b0}}};
  assign quo[0] = '0;
  assign emp[0] = empty;

  for (genvar i = 0; i < QW; i++) begin : g_step
    bir_div_step #(
      .DW (DW),
      .QW (QW)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vld[i]),
      .rem_in    (rem[i]),
      .den_in    (den[i]),
      .nb_in     (nb[i]),
      .q_in      (quo[i]),
      .empty_in  (emp[i]),
      .out_valid (vld[i+1]),
      .rem_out   (rem[i+1]),
      .den_out   (den[i+1]),
      .nb_out    (nb[i+1]),
      .q_out     (quo[i+1]),
      .empty_out (emp[i+1])
    );
  end

  assign out_valid = vld[QW];
  assign out_empty = emp[QW];
  assign ratio     = emp[QW] ? '0 : quo[QW];

endmodule

`default_nettype wire

/* sv/box_iou_ratio_top.sv */
// ----------------------------------------------------------------------------
// box_iou_ratio_top - intersection over union of two axis-aligned boxes
// Streams box pairs in and overlap ratios out, one pair per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   s_* beat carries one box pair: corner x, y, width and height of each box.
//   m_* beat carries the ratio intersection/union in unsigned Q1.FRAC_BITS
//   (2^FRAC_BITS is exactly one), truncated; m_tuser flags a zero union,
//   in which case the ratio reads zero.
//   From input beat to output valid a pair passes four geometry stages,
//   then one stage per quotient bit of the divider. Every stage holds its
//   own valid bit; throughput is one beat per cycle unless the output stalls.
//   When m_tready is low with a result waiting, the whole pipeline freezes
//   and s_tready drops in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits; s_tready is high right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module box_iou_ratio_top
  import bir_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // first_x, first_y, first_width, first_height,
  // second_x, second_y, second_width, second_height
  input  wire logic [8*COORD_BITS-1:0]            s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // overlap_ratio, zero padded
  output logic [((FRAC_BITS+8)/8)*8-1:0]          m_tdata,
  // union_empty
  output logic                                    m_tuser
);

  localparam int C = COORD_BITS;

  logic                 en;
  logic                 g_valid;
  logic [2*C-1:0]       g_inter;
  logic [2*C:0]         g_uni;
  logic                 g_empty;
  logic [FRAC_BITS:0]   ratio;

  // whole pipeline advances unless a result waits on the output with m_tready low
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  bir_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (s_tvalid),
    .first_x       (s_tdata[0*C +: C]),
    .first_y       (s_tdata[1*C +: C]),
    .first_width   (s_tdata[2*C +: C]),
    .first_height  (s_tdata[3*C +: C]),
    .second_x      (s_tdata[4*C +: C]),
    .second_y      (s_tdata[5*C +: C]),
    .second_width  (s_tdata[6*C +: C]),
    .second_height (s_tdata[7*C +: C]),
    .out_valid     (g_valid),
    .inter         (g_inter),
    .uni           (g_uni),
    .empty         (g_empty)
  );

  bir_divider #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .inter     (g_inter),
    .uni       (g_uni),
    .empty     (g_empty),
    .out_valid (m_tvalid),
    .ratio     (ratio),
    .out_empty (m_tuser)
  );

  assign m_tdata = (((FRAC_BITS+8)/8)*8)'(ratio);

`ifndef SYNTHESIS
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> ratio == '0)
    else $error("empty union with nonzero ratio");

  a_ratio_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ratio <= {1'b1, {FRAC_BITS{1'b0}}})
    else $error("ratio above one");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb - self-checking bench for box_iou_ratio_top
// Streams box pairs through the block and compares every overlap ratio and
// empty-union flag against bit-exact expected values. A short directed table
// covers extremes and corner geometry, then random pairs of several shapes
// follow with bursty input, output stalls, one long output hold and a drain.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import bir_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB        = COORD_BITS_DEF;
  localparam int FB        = FRAC_BITS_DEF;
  localparam int RATIO_W   = FB + 1;
  localparam int M_DATA_W  = ((FB + 8) / 8) * 8;
  localparam int LATENCY   = FB + 5;
  localparam int LONG_HOLD = 400;
  localparam int LIMIT     = 300000;

  localparam logic [CB-1:0]      CMAX = '1;
  localparam logic [RATIO_W-1:0] ONE  = RATIO_W'(1) << FB;

  typedef struct packed {
    logic [CB-1:0] first_x, first_y, first_width, first_height;
    logic [CB-1:0] second_x, second_y, second_width, second_height;
  } box_pair_t;

  typedef struct packed {
    logic [RATIO_W-1:0] overlap_ratio;
    logic               union_empty;
  } iou_t;

  typedef struct packed {
    box_pair_t pair;
    logic      fixed;  // result typed in below, else predicted
    iou_t      res;
  } dir_row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_THREE_IN_FOUR, RX_RARE_STALL} rx_mode_t;

  localparam dir_row_t DIR_ROWS [0:17] = '{
    // both boxes empty
    '{'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, '{'0, 1'b1}},
    // all fields at max, identical
    '{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1, '{ONE, 1'b0}},
    // zero widths, full heights
    '{'{CMAX, 12'd0, 12'd0, CMAX, 12'd0, CMAX, 12'd0, CMAX}, 1'b1, '{'0, 1'b1}},
    '{'{12'd5, 12'd7, 12'd10, 12'd20, 12'd5, 12'd7, 12'd10, 12'd20}, 1'b1, '{ONE, 1'b0}},
    // disjoint
    '{'{12'd0, 12'd0, 12'd10, 12'd10, 12'd100, 12'd100, 12'd10, 12'd10}, 1'b1, '{'0, 1'b0}},
    // touching along x, then along y
    '{'{12'd0, 12'd0, 12'd10, 12'd10, 12'd10, 12'd0, 12'd10, 12'd10}, 1'b1, '{'0, 1'b0}},
    '{'{12'd0, 12'd0, 12'd10, 12'd10, 12'd0, 12'd10, 12'd10, 12'd10}, 1'b1, '{'0, 1'b0}},
    // degenerate first box inside a real one
    '{'{12'd5, 12'd5, 12'd0, 12'd10, 12'd0, 12'd0, 12'd20, 12'd20}, 1'b1, '{'0, 1'b0}},
    '{'{12'd0, 12'd0, 12'd100, 12'd100, 12'd10, 12'd10, 12'd10, 12'd10}, 1'b0, '0},
    // one third, truncated
    '{'{12'd0, 12'd0, 12'd3, 12'd1, 12'd0, 12'd0, 12'd1, 12'd1}, 1'b0, '0},
    '{'{CMAX, CMAX, 12'd1, 12'd1, CMAX, CMAX, 12'd1, 12'd1}, 1'b1, '{ONE, 1'b0}},
    '{'{12'd0, 12'd0, CMAX, CMAX, 12'd0, 12'd0, 12'd1, 12'd1}, 1'b0, '0},
    // edges run past the coordinate range
    '{'{12'd4000, 12'd4000, CMAX, CMAX, 12'd4090, 12'd4090, CMAX, CMAX}, 1'b0, '0},
    '{'{12'd10, 12'd10, 12'd10, 12'd10, 12'd0, 12'd0, 12'd100, 12'd100}, 1'b0, '0},
    '{'{12'd0, 12'd0, CMAX, CMAX, 12'd1, 12'd1, CMAX, CMAX}, 1'b0, '0},
    '{'{CMAX, 12'd0, CMAX, 12'd0, 12'd0, CMAX, CMAX, 12'd0}, 1'b1, '{'0, 1'b1}},
    '{'{CMAX, CMAX, 12'd0, 12'd0, 12'd0, 12'd0, CMAX, CMAX}, 1'b1, '{'0, 1'b0}},
    '{'{12'd2047, 12'd1024, 12'd3000, 12'd17, CMAX, 12'd1030, 12'd1, 12'd2}, 1'b0, '0}
  };

  logic                rst      = 1'b1;
  logic                clk      = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [8*CB-1:0]     s_tdata  = '0;
  logic                m_tready = 1'b0;
  logic                s_tready;
  logic                m_tvalid;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tuser;

  iou_t     pending_results [$];
  int       n_errors = 0;
  int       n_pairs = 0;
  int       n_results = 0;
  int       n_empty = 0;
  int       n_exact = 0;
  int       cycle_cnt = 0;
  int       burst_left = 0;
  bit       gapless = 1'b0;
  logic     long_hold_req = 1'b0;
  logic     long_hold_done = 1'b0;
  int       hold_cnt = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  box_iou_ratio_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // overlap of [a0, a0+alen) and [b0, b0+blen), clamped at zero
  function automatic logic [CB-1:0] overlap_len(logic [CB-1:0] a0, logic [CB-1:0] alen,
                                                logic [CB-1:0] b0, logic [CB-1:0] blen);
    logic [CB:0] a1, b1, lo, hi;
    a1 = {1'b0, a0} + alen;
    b1 = {1'b0, b0} + blen;
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? CB'(hi - lo) : '0;
  endfunction

  function automatic iou_t iou_of_pair(box_pair_t p);
    logic [CB-1:0]      iw, ih;
    logic [2*CB-1:0]    inter, area_a, area_b;
    logic [2*CB:0]      uni;
    logic [2*CB+FB-1:0] numer;
    iou_t               r;
    iw     = overlap_len(p.first_x, p.first_width, p.second_x, p.second_width);
    ih     = overlap_len(p.first_y, p.first_height, p.second_y, p.second_height);
    inter  = iw * ih;
    area_a = p.first_width * p.first_height;
    area_b = p.second_width * p.second_height;
    uni    = area_a + area_b - inter;
    numer  = {inter, FB'(0)};
    if (uni == 0) begin
      r.overlap_ratio = '0;
      r.union_empty   = 1'b1;
    end else begin
      r.overlap_ratio = RATIO_W'(numer / uni);
      r.union_empty   = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [8*CB-1:0] pack_pair(box_pair_t p);
    return {p.second_height, p.second_width, p.second_y, p.second_x,
            p.first_height, p.first_width, p.first_y, p.first_x};
  endfunction

  function automatic logic [CB-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > int'(CMAX)) return CMAX;
    return CB'(v);
  endfunction

  function automatic logic [CB-1:0] near(logic [CB-1:0] base, int span);
    return clamp_coord(int'(base) - span + int'($urandom_range(0, 2 * span)));
  endfunction

  function automatic logic [CB-1:0] edge_or_any();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CB'(1);
      2: return CMAX - 1'b1;
      3: return CMAX;
      default: return CB'($urandom_range(0, CMAX));
    endcase
  endfunction

  function automatic box_pair_t rand_pair();
    box_pair_t p;
    int        zmask;
    p = box_pair_t'({$urandom, $urandom, $urandom});
    case ($urandom_range(0, 9))
      2, 3: begin
        // small boxes close together
        p.first_width   = CB'($urandom_range(0, 64));
        p.first_height  = CB'($urandom_range(0, 64));
        p.second_x      = near(p.first_x, 48);
        p.second_y      = near(p.first_y, 48);
        p.second_width  = CB'($urandom_range(0, 64));
        p.second_height = CB'($urandom_range(0, 64));
      end
      4: begin
        p.second_x      = p.first_x;
        p.second_y      = p.first_y;
        p.second_width  = p.first_width;
        p.second_height = p.first_height;
      end
      5: begin
        // second box starts within the first or on its far edge, no larger than it
        p.second_x      = clamp_coord(int'(p.first_x) + $urandom_range(0, p.first_width));
        p.second_y      = clamp_coord(int'(p.first_y) + $urandom_range(0, p.first_height));
        p.second_width  = CB'($urandom_range(0, p.first_width));
        p.second_height = CB'($urandom_range(0, p.first_height));
      end
      6: begin
        zmask = $urandom_range(1, 15);
        if (zmask[0]) p.first_width = '0;
        if (zmask[1]) p.first_height = '0;
        if (zmask[2]) p.second_width = '0;
        if (zmask[3]) p.second_height = '0;
      end
      7: begin
        p.first_x       = edge_or_any();
        p.first_y       = edge_or_any();
        p.first_width   = edge_or_any();
        p.first_height  = edge_or_any();
        p.second_x      = edge_or_any();
        p.second_y      = edge_or_any();
        p.second_width  = edge_or_any();
        p.second_height = edge_or_any();
      end
      8, 9: begin
        p.first_width   = CB'($urandom_range(0, 512));
        p.first_height  = CB'($urandom_range(0, 512));
        p.second_x      = near(p.first_x, 300);
        p.second_y      = near(p.first_y, 300);
        p.second_width  = CB'($urandom_range(0, 512));
        p.second_height = CB'($urandom_range(0, 512));
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  task automatic offer_pair(input box_pair_t p, input logic fixed, input iou_t res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gapless || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tdata  <= pack_pair(p);
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results = {pending_results, (fixed ? res : iou_of_pair(p))};
    n_pairs++;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_failure(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("mismatch %0d: %s", n_errors, msg);
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIR_ROWS[i]) offer_pair(DIR_ROWS[i].pair, DIR_ROWS[i].fixed, DIR_ROWS[i].res);
    repeat (700) offer_pair(rand_pair(), 1'b0, '0);
    // keep offering back to back while the output is held off
    gapless = 1'b1;
    long_hold_req <= 1'b1;
    repeat (200) offer_pair(rand_pair(), 1'b0, '0);
    gapless = 1'b0;
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (750) offer_pair(rand_pair(), 1'b0, '0);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    $display("sent %0d box pairs, checked %0d results (%0d empty unions, %0d full overlaps)",
             n_pairs, n_results, n_empty, n_exact);
    $display("with bursty input, random output stalls, a %0d-cycle output hold and a drain",
             LONG_HOLD);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // output backpressure: random modes, plus one long hold on request
  always @(posedge clk) begin : sink_ready
    if (long_hold_req && !long_hold_done) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == LONG_HOLD - 1) long_hold_done <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(16, 96);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:          m_tready <= 1'b1;
        RX_COIN:          m_tready <= 1'($urandom_range(0, 1));
        RX_THREE_IN_FOUR: m_tready <= (cycle_cnt % 4) != 0;
        default:          m_tready <= $urandom_range(0, 9) != 0;
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    iou_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.overlap_ratio = m_tdata[RATIO_W-1:0];
      got.union_empty   = m_tuser;
      n_results++;
      if (got.union_empty) n_empty++;
      if (got.overlap_ratio == ONE) n_exact++;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected beat ratio=%0d empty=%0b",
                               got.overlap_ratio, got.union_empty));
      end else begin
        want = pending_results.pop_front();
        if (want != got)
          note_failure($sformatf("beat %0d: expected ratio=%0d empty=%0b, got ratio=%0d empty=%0b",
                                 n_results, want.overlap_ratio, want.union_empty,
                                 got.overlap_ratio, got.union_empty));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

`default_nettype wire

/* box_iou_ratio_top.f */
sv/bir_pkg.sv
sv/bir_geom.sv
sv/bir_div_step.sv
sv/bir_divider.sv
sv/box_iou_ratio_top.sv
tb/tb.sv
